@@ rtl/frfo_pkg.sv @@
package frfo_pkg;

    localparam int MAX_FRAMES_DEF  = 16;
    localparam int FRAME_BYTES_DEF = 4;

    localparam int FUNC_W    = 2;
    localparam int DATA_W    = 32;
    localparam int USED_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INFO  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WHEN_FULL = 2'd1;

    localparam logic [CFG_DAT_W-1:0] FRAMES_IN_USE_RST = 5'd16;

    // Status of one operation, waiting for its frame data to come out of the RAM
    typedef struct packed {
        logic              done;
        logic              rd_ok;
        logic [USED_W-1:0] used;
        logic              ovf;
        logic              blk;
    } frfo_stat_t;

endpackage

@@ rtl/frfo_ram.sv @@
module frfo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // read data holds when not enabled
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/frame_ring_fifo_overwrite.sv @@
// An accepted transfer is registered in the pend stage, then in the out stage that
// drives m_*. Throughput: one operation per cycle while m_ready does not hold the
// result stages; indices and flags update in the accept cycle, and the frame RAM's
// registered read port sets the two-stage path. Reset (aresetn low, synchronous):
// indices and overflow cleared, frames_in_use 16 or MAX_FRAMES if smaller,
// block_when_full 0, both result stages empty. Frame RAM contents are not cleared.
module frame_ring_fifo_overwrite
    import frfo_pkg::*;
#(
    parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FUNC_W-1:0]    s_func,
    input  logic [DATA_W-1:0]    s_write_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_done_res,
    output logic [DATA_W-1:0]    m_read_data,
    output logic [USED_W-1:0]    m_used_frames,
    output logic                 m_overflow_seen,
    output logic                 m_block_mode,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int IDX_W   = $clog2(MAX_FRAMES);
    localparam int CNT_W   = IDX_W + 1;                       // holds the slot count
    localparam int SW      = (CNT_W > CFG_DAT_W) ? CNT_W : CFG_DAT_W;
    localparam int FRAME_W = 8 * FRAME_BYTES;

    // ---------------------------------------------------------------------
    // Ring state
    // ---------------------------------------------------------------------
    logic [CNT_W-1:0] slots_reg,  slots_next;   // effective ring size, clamped
    logic             blk_reg,    blk_next;
    logic [IDX_W-1:0] widx_reg,   widx_next;
    logic [IDX_W-1:0] ridx_reg,   ridx_next;
    logic             ovf_reg,    ovf_next;

    // Pipeline: pend stage waits on RAM read data, out stage feeds m_*
    logic             pend_valid_reg, pend_valid_next;
    frfo_stat_t       pend_reg,       pend_next;
    logic             out_valid_reg,  out_valid_next;
    frfo_stat_t       out_reg,        out_next;
    logic [DATA_W-1:0] out_data_reg,  out_data_next;

    logic             s_xfer;
    logic             cfg_xfer;
    logic             pend_move;

    // RAM side
    logic               ram_we;
    logic               ram_re;
    logic [FRAME_W-1:0] ram_wdata;
    logic [FRAME_W-1:0] ram_rdata;

    // Op decode helpers
    logic [IDX_W-1:0] widx_adv;
    logic [IDX_W-1:0] ridx_adv;
    logic             full;
    logic             wr_ok;
    logic             rd_ok;
    logic [CNT_W-1:0] used;
    logic [31:0]      used_ext;
    logic [63:0]      wdata_ext;
    logic [63:0]      rdata_ext;
    logic [SW-1:0]    cfg_fiu;
    logic [SW-1:0]    cfg_slots;

    // next index around the ring of slots_reg entries
    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] nx;
        nx = {1'b0, idx} + CNT_W'(1);
        return (nx >= n) ? '0 : nx[IDX_W-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid & cfg_ready;

    // pend advances when the out register is empty or drains this cycle
    assign pend_move = pend_valid_reg & (~out_valid_reg | m_ready);
    // new op only if pend is free after this edge; the RAM read port then
    // holds its data while pend is stalled
    assign s_ready   = ~pend_valid_reg | pend_move;
    assign s_xfer    = s_valid & s_ready;

    // ---------------------------------------------------------------------
    // Operation logic: indices and flags settle in the accept cycle
    // ---------------------------------------------------------------------
    assign widx_adv = advance(widx_reg, slots_reg);
    assign ridx_adv = advance(ridx_reg, slots_reg);
    assign full     = (widx_adv == ridx_reg);
    assign wr_ok    = ~full | ~blk_reg;
    assign rd_ok    = (widx_reg != ridx_reg);

    assign wdata_ext = 64'(s_write_data);
    assign ram_wdata = wdata_ext[FRAME_W-1:0];
    assign ram_we    = s_xfer & (s_func == FUNC_WRITE) & wr_ok;
    assign ram_re    = s_xfer & (s_func == FUNC_READ) & rd_ok;

    // frames_in_use clamped to 2..MAX_FRAMES
    assign cfg_fiu   = SW'(cfg_data);
    assign cfg_slots = (cfg_fiu < SW'(2)) ? SW'(2) :
                       (cfg_fiu > SW'(MAX_FRAMES)) ? SW'(MAX_FRAMES) : cfg_fiu;

    always_comb begin
        slots_next      = slots_reg;
        blk_next        = blk_reg;
        widx_next       = widx_reg;
        ridx_next       = ridx_reg;
        ovf_next        = ovf_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        used            = '0;
        used_ext        = '0;
        rdata_ext       = 64'(ram_rdata);

        // output stage
        if (pend_move) begin
            out_valid_next = 1'b1;
            out_next       = pend_reg;
            out_data_next  = pend_reg.rd_ok ? rdata_ext[DATA_W-1:0] : '0;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        if (pend_move) begin
            pend_valid_next = 1'b0;
        end

        if (s_xfer) begin
            pend_valid_next = 1'b1;
            pend_next.done  = 1'b1;
            pend_next.rd_ok = 1'b0;
            pend_next.blk   = blk_reg;

            case (s_func)
                FUNC_WRITE: begin
                    pend_next.done = wr_ok;
                    if (wr_ok) begin
                        // overwrite mode on a full ring drops the oldest frame
                        if (full) begin
                            ridx_next = ridx_adv;
                            ovf_next  = 1'b1;
                        end
                        widx_next = widx_adv;
                    end
                end
                FUNC_READ: begin
                    pend_next.done  = rd_ok;
                    pend_next.rd_ok = rd_ok;
                    if (rd_ok) begin
                        ridx_next = ridx_adv;
                    end
                end
                FUNC_FLUSH: begin
                    widx_next = '0;
                    ridx_next = '0;
                    ovf_next  = 1'b0;
                end
                default: begin
                end
            endcase

            used = (widx_next >= ridx_next) ?
                   (CNT_W'(widx_next) - CNT_W'(ridx_next)) :
                   (slots_reg - CNT_W'(ridx_next) + CNT_W'(widx_next));
            used_ext       = 32'(used);
            pend_next.used = used_ext[USED_W-1:0];
            pend_next.ovf  = ovf_next;

            // info reports the flag, then clears it
            if (s_func == FUNC_INFO) begin
                ovf_next = 1'b0;
            end
        end

        // user sends configuration writes only while the block is idle; unchecked
        if (cfg_xfer) begin
            case (cfg_index)
                CFG_FRAMES_IN_USE: begin
                    slots_next = cfg_slots[CNT_W-1:0];
                    widx_next  = '0;
                    ridx_next  = '0;
                end
                CFG_BLOCK_WHEN_FULL: begin
                    blk_next = cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg      <= CNT_W'(MAX_FRAMES < 16 ? MAX_FRAMES : 16);
            blk_reg        <= 1'b0;
            widx_reg       <= '0;
            ridx_reg       <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            slots_reg      <= slots_next;
            blk_reg        <= blk_next;
            widx_reg       <= widx_next;
            ridx_reg       <= ridx_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_data_reg <= out_data_next;
    end

    frfo_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (MAX_FRAMES)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (widx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ridx_reg),
        .rdata (ram_rdata)
    );

    assign m_valid         = out_valid_reg;
    assign m_done_res      = out_reg.done;
    assign m_read_data     = out_data_reg;
    assign m_used_frames   = out_reg.used;
    assign m_overflow_seen = out_reg.ovf;
    assign m_block_mode    = out_reg.blk;

endmodule
